[rtl/ace_pkg.sv]
package ace_pkg;

  localparam int unsigned AddrW = 8;
  localparam int unsigned DataW = 8;
  localparam int unsigned MemDepth = 1 << AddrW;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_EXEC  = 2'd2
  } op_e;

  localparam logic [DataW-1:0] OPC_NOP = 8'd0;
  localparam logic [DataW-1:0] OPC_STA = 8'd16;
  localparam logic [DataW-1:0] OPC_LDA = 8'd32;
  localparam logic [DataW-1:0] OPC_ADD = 8'd48;
  localparam logic [DataW-1:0] OPC_OR  = 8'd64;
  localparam logic [DataW-1:0] OPC_AND = 8'd80;
  localparam logic [DataW-1:0] OPC_NOT = 8'd96;
  localparam logic [DataW-1:0] OPC_JMP = 8'd128;
  localparam logic [DataW-1:0] OPC_JN  = 8'd144;
  localparam logic [DataW-1:0] OPC_JZ  = 8'd160;
  localparam logic [DataW-1:0] OPC_HLT = 8'd240;

  typedef struct packed {
    logic [1:0]       operation;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic [AddrW-1:0] program_counter;
    logic [DataW-1:0] accumulator;
    logic             negative_flag;
    logic             zero_flag;
    logic             halted;
  } res_t;

  typedef struct packed {
    logic             en;
    logic             we;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata;
  } ram_req_t;

endpackage

[rtl/ace_if.sv]
interface ace_in_if import ace_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       operation;
  logic [AddrW-1:0] address;
  logic [DataW-1:0] write_data;

  modport source (output valid, output operation, output address, output write_data,
                  input ready);
  modport sink (input valid, input operation, input address, input write_data,
                output ready);
endinterface

interface ace_out_if import ace_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] read_data;
  logic [AddrW-1:0] program_counter;
  logic [DataW-1:0] accumulator;
  logic             negative_flag;
  logic             zero_flag;
  logic             halted;

  modport source (output valid, output read_data, output program_counter,
                  output accumulator, output negative_flag, output zero_flag,
                  output halted, input ready);
  modport sink (input valid, input read_data, input program_counter,
                input accumulator, input negative_flag, input zero_flag,
                input halted, output ready);
endinterface

[rtl/ace_ram.sv]
module ace_ram import ace_pkg::*; (
  input  logic             clk_i,
  input  ram_req_t         req_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [MemDepth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_q <= mem[req_i.addr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ace_core.sv]
module ace_core import ace_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  item_t            item_i,
  input  logic             item_valid_i,
  output logic             item_take_o,
  output ram_req_t         ram_req_o,
  input  logic [DataW-1:0] ram_rdata_i,
  output res_t             res_o,
  output logic             res_valid_o,
  input  logic             res_ready_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_OPC,
    S_EA,
    S_DAT
  } state_e;

  state_e           state_q, state_d;
  logic [AddrW-1:0] pc_q, pc_d;
  logic [DataW-1:0] acc_q, acc_d;
  logic             n_q, n_d;
  logic             z_q, z_d;
  logic             halt_q, halt_d;
  logic [DataW-1:0] opc_q, opc_d;
  res_t             res_q, res_d;
  logic             res_valid_q;
  logic             out_free;
  logic             fin;
  logic             alu_en;
  logic [DataW-1:0] alu_v;
  logic [DataW-1:0] rd_v;

  assign out_free = !res_valid_q || res_ready_i;

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    acc_d       = acc_q;
    n_d         = n_q;
    z_d         = z_q;
    halt_d      = halt_q;
    opc_d       = opc_q;
    ram_req_o   = '0;
    item_take_o = 1'b0;
    fin         = 1'b0;
    alu_en      = 1'b0;
    alu_v       = '0;
    rd_v        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i && out_free) begin
          item_take_o = 1'b1;
          case (op_e'(item_i.operation))
            OP_WRITE: begin
              ram_req_o = '{en: 1'b1, we: 1'b1, addr: item_i.address,
                            wdata: item_i.write_data};
              fin = 1'b1;
            end
            OP_READ: begin
              ram_req_o = '{en: 1'b1, we: 1'b0, addr: item_i.address, wdata: '0};
              state_d = S_RD;
            end
            OP_EXEC: begin
              if (halt_q) begin
                fin = 1'b1;
              end else begin
                ram_req_o = '{en: 1'b1, we: 1'b0, addr: pc_q, wdata: '0};
                state_d = S_OPC;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_RD: begin
        rd_v = ram_rdata_i;
        fin  = 1'b1;
      end
      S_OPC: begin
        opc_d = ram_rdata_i;
        case (ram_rdata_i) inside
          OPC_STA, OPC_LDA, OPC_ADD, OPC_OR, OPC_AND, OPC_JMP, OPC_JN, OPC_JZ: begin
            ram_req_o = '{en: 1'b1, we: 1'b0, addr: pc_q + 8'd1, wdata: '0};
            state_d = S_EA;
          end
          OPC_NOT: begin
            alu_en = 1'b1;
            alu_v  = ~acc_q;
            pc_d   = pc_q + 8'd1;
            fin    = 1'b1;
          end
          OPC_HLT: begin
            halt_d = 1'b1;
            pc_d   = pc_q + 8'd1;
            fin    = 1'b1;
          end
          default: begin
            pc_d = pc_q + 8'd1;
            fin  = 1'b1;
          end
        endcase
      end
      S_EA: begin
        case (opc_q) inside
          OPC_JMP: begin
            pc_d = ram_rdata_i;
            fin  = 1'b1;
          end
          OPC_JN: begin
            pc_d = n_q ? ram_rdata_i : pc_q + 8'd2;
            fin  = 1'b1;
          end
          OPC_JZ: begin
            pc_d = z_q ? ram_rdata_i : pc_q + 8'd2;
            fin  = 1'b1;
          end
          OPC_STA: begin
            ram_req_o = '{en: 1'b1, we: 1'b1, addr: ram_rdata_i, wdata: acc_q};
            pc_d = pc_q + 8'd2;
            fin  = 1'b1;
          end
          default: begin
            ram_req_o = '{en: 1'b1, we: 1'b0, addr: ram_rdata_i, wdata: '0};
            state_d = S_DAT;
          end
        endcase
      end
      S_DAT: begin
        alu_en = 1'b1;
        case (opc_q) inside
          OPC_LDA: alu_v = ram_rdata_i;
          OPC_ADD: alu_v = acc_q + ram_rdata_i;
          OPC_OR:  alu_v = acc_q | ram_rdata_i;
          default: alu_v = acc_q & ram_rdata_i;
        endcase
        pc_d = pc_q + 8'd2;
        fin  = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase

    if (alu_en) begin
      acc_d = alu_v;
      n_d   = alu_v[DataW-1];
      z_d   = (alu_v == '0);
    end
    if (fin) begin
      state_d = S_IDLE;
    end

    res_d = '{read_data: rd_v, program_counter: pc_d, accumulator: acc_d,
              negative_flag: n_d, zero_flag: z_d, halted: halt_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      acc_q       <= '0;
      n_q         <= 1'b0;
      z_q         <= 1'b0;
      halt_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      acc_q   <= acc_d;
      n_q     <= n_d;
      z_q     <= z_d;
      halt_q  <= halt_d;
      if (fin) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    opc_q <= opc_d;
    if (fin) begin
      res_q <= res_d;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

[rtl/accumulator_cpu_executor_top.sv]
// Accumulator processor with a 256-byte program/data memory.
// in_i carries one beat per item: operation selects a memory byte write,
// a memory byte read, or execution of one instruction at the program counter.
// out_o returns exactly one beat per item, in order, holding the read byte
// (zero unless a read), the program counter, accumulator, N and Z flags and
// the halted bit as they stand after that item.
// A one-entry input buffer takes a new beat while the previous item is still
// being worked on; a registered output beat holds while out_o.ready is low,
// and the core does not start another item until that beat can be replaced.
// All memory traffic goes through one single-port RAM with a registered read
// port. An execute reads the opcode at the program counter; jumps and STA then
// read the operand address, and LDA, ADD, OR and AND also read the operand at
// that address (opcode, operand address, operand). The core starts an item only
// when the output is free, and the result beat is registered. Once halted,
// execute beats do not touch memory. Back-to-back writes sustain one beat per cycle while out_o.ready stays high.
// Reset clears the program counter, accumulator, flags and halt bit; memory
// contents are undefined until written.
module accumulator_cpu_executor_top import ace_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  ace_in_if.sink           in_i,
  ace_out_if.source        out_o
);

  item_t            buf_q;
  logic             buf_valid_q;
  logic             take;
  logic             accept;
  ram_req_t         ram_req;
  logic [DataW-1:0] ram_rdata;
  res_t             res;
  logic             res_valid;

  assign in_i.ready = !buf_valid_q || take;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
    end else if (accept) begin
      buf_valid_q <= 1'b1;
    end else if (take) begin
      buf_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      buf_q <= '{operation: in_i.operation, address: in_i.address,
                 write_data: in_i.write_data};
    end
  end

  ace_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (buf_q),
    .item_valid_i (buf_valid_q),
    .item_take_o  (take),
    .ram_req_o    (ram_req),
    .ram_rdata_i  (ram_rdata),
    .res_o        (res),
    .res_valid_o  (res_valid),
    .res_ready_i  (out_o.ready)
  );

  ace_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign out_o.valid           = res_valid;
  assign out_o.read_data       = res.read_data;
  assign out_o.program_counter = res.program_counter;
  assign out_o.accumulator     = res.accumulator;
  assign out_o.negative_flag   = res.negative_flag;
  assign out_o.zero_flag       = res.zero_flag;
  assign out_o.halted          = res.halted;

endmodule
